// ===== src/lvp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lvp_pkg: shared types for the longest valid parentheses unit
// Transaction payloads, character codes and the cell shift operation.
// ----------------------------------------------------------------------------
package lvp_pkg;

  localparam int unsigned SymbolWidth = 8;
  localparam int unsigned BestWidth   = 16;

  localparam logic [SymbolWidth-1:0] OPEN_CHAR  = 8'h28;
  localparam logic [SymbolWidth-1:0] CLOSE_CHAR = 8'h29;

  typedef struct packed {
    logic [SymbolWidth-1:0] symbol;
    logic                   start_req;
  } lvp_in_t;

  typedef struct packed {
    logic [BestWidth-1:0] best_length;
    logic                 overflow;
  } lvp_out_t;

  // What a stack cell loads at the next edge.
  typedef enum logic [3:0] {
    CELL_HOLD     = 4'b0001,
    CELL_TAKE_UP  = 4'b0010,
    CELL_TAKE_DN1 = 4'b0100,
    CELL_TAKE_DN2 = 4'b1000
  } lvp_cell_op_t;

  typedef struct packed {
    lvp_cell_op_t op;
  } lvp_cell_ctrl_t;

endpackage

// ===== src/lvp_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lvp_cell: one stack entry of the shifting stack
// Holds one entry and loads from the entry above or one or two entries below.
// ----------------------------------------------------------------------------
module lvp_cell
  import lvp_pkg::*;
#(
  parameter int unsigned LENGTH_WIDTH = 16
) (
  input  logic                    clk,
  input  lvp_cell_ctrl_t          ctrl,
  input  logic [LENGTH_WIDTH-1:0] up_val,
  input  logic [LENGTH_WIDTH-1:0] dn1_val,
  input  logic [LENGTH_WIDTH-1:0] dn2_val,
  output logic [LENGTH_WIDTH-1:0] val
);

  logic [LENGTH_WIDTH-1:0] val_r;
  logic [LENGTH_WIDTH-1:0] val_nxt;

  always_comb begin
    unique case (ctrl.op)
      CELL_TAKE_UP:  val_nxt = up_val;
      CELL_TAKE_DN1: val_nxt = dn1_val;
      CELL_TAKE_DN2: val_nxt = dn2_val;
      default:       val_nxt = val_r;
    endcase
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val = val_r;

endmodule

// ===== src/longest_valid_parentheses_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// longest_valid_parentheses_unit: streaming longest balanced bracket run
// Scans one character per transaction and reports the longest balanced run.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid / in_ready / in_data) carries one character
//   per transaction together with a start_req flag that opens a new string.
//   Every input transaction produces exactly one output transaction
//   (out_valid / out_ready / out_data) with the best length so far in the
//   current string and the sticky overflow flag.
//   The result of a character is registered and shows on the output in the
//   cycle after the input transaction. Throughput is one character per cycle
//   while the receiver does not stall; the stack is a row of cells that all
//   shift in the same cycle; every decision looks only at the top three cells.
//   When the receiver stalls, the result stays in the output register and
//   in_ready drops; a new character is taken in the same cycle that the
//   waiting result is taken.
//   After reset the stack is empty, the best length is zero and overflow
//   is clear; no clearing pass is needed since entries at or above the
//   fill count are never looked at.
// ----------------------------------------------------------------------------
module longest_valid_parentheses_unit
  import lvp_pkg::*;
#(
  parameter int unsigned STACK_DEPTH  = 64,
  parameter int unsigned LENGTH_WIDTH = 16
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  lvp_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output lvp_out_t out_data
);

  localparam int unsigned CntWidth = $clog2(STACK_DEPTH + 1);
  localparam logic [CntWidth-1:0] CntFull = CntWidth'(STACK_DEPTH);

  // Stack state: the top of stack sits in cell 0.
  logic [LENGTH_WIDTH-1:0] cell_val [STACK_DEPTH];
  logic [LENGTH_WIDTH-1:0] top_val  [3];
  lvp_cell_ctrl_t          cell_ctrl [STACK_DEPTH];
  logic [LENGTH_WIDTH-1:0] top_load;

  logic [CntWidth-1:0]     cnt_r, cnt_nxt;
  logic [LENGTH_WIDTH-1:0] best_r, best_nxt;
  logic                    ovf_r, ovf_nxt;
  logic                    out_valid_r;
  lvp_out_t                out_data_r;

  logic in_fire;
  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  // Values of the top three entries; cells beyond the depth read as zero,
  // but the fill count always guards those reads.
  for (genvar k = 0; k < 3; k++) begin : g_top
    if (k < STACK_DEPTH) begin : g_real
      assign top_val[k] = cell_val[k];
    end else begin : g_none
      assign top_val[k] = '0;
    end
  end

  // Decode of the current character against the top of the stack.
  logic [CntWidth-1:0]     eff_cnt;
  logic [LENGTH_WIDTH-1:0] eff_best;
  logic                    eff_ovf;
  logic                    is_open, is_close, push_ok;
  logic                    take_a, take_b, has_marker;
  logic [LENGTH_WIDTH-1:0] run_a, marker_val, below_val, run2, run3;
  logic [LENGTH_WIDTH:0]   sum1, sum2;
  logic                    merge;

  always_comb begin
    // A start request empties everything before this character is applied.
    eff_cnt  = in_data.start_req ? '0 : cnt_r;
    eff_best = in_data.start_req ? '0 : best_r;
    eff_ovf  = in_data.start_req ? 1'b0 : ovf_r;

    is_open  = (in_data.symbol == OPEN_CHAR);
    is_close = (in_data.symbol == CLOSE_CHAR);
    push_ok  = is_open && (eff_cnt != CntFull);

    // A closed run on top is lifted off first; the marker must sit under it.
    take_a     = (eff_cnt > CntWidth'(0)) && (top_val[0] != '0);
    run_a      = take_a ? top_val[0] : '0;
    marker_val = take_a ? top_val[1] : top_val[0];
    below_val  = take_a ? top_val[2] : top_val[1];
    has_marker = take_a ? ((eff_cnt > CntWidth'(1)) && (marker_val == '0))
                        : ((eff_cnt > CntWidth'(0)) && (marker_val == '0));
    take_b     = take_a ? ((eff_cnt > CntWidth'(2)) && (below_val != '0))
                        : ((eff_cnt > CntWidth'(1)) && (below_val != '0));

    // Saturating sums: a saturated run stays nonzero and is never a marker.
    sum1 = {1'b0, run_a} + (LENGTH_WIDTH + 1)'(2);
    run2 = sum1[LENGTH_WIDTH] ? '1 : sum1[LENGTH_WIDTH-1:0];
    sum2 = {1'b0, run2} + {1'b0, below_val};
    run3 = !take_b ? run2 : (sum2[LENGTH_WIDTH] ? '1 : sum2[LENGTH_WIDTH-1:0]);

    merge = is_close && has_marker;

    cnt_nxt  = eff_cnt;
    best_nxt = eff_best;
    ovf_nxt  = eff_ovf;
    top_load = '0;
    if (push_ok) begin
      cnt_nxt = eff_cnt + CntWidth'(1);
    end else if (is_open) begin
      ovf_nxt = 1'b1;
    end else if (merge) begin
      // Removes run, marker and lower run, then pushes the merged run.
      cnt_nxt  = eff_cnt - CntWidth'(take_a) - CntWidth'(take_b);
      top_load = run3;
      if (run3 > eff_best) begin
        best_nxt = run3;
      end
    end else if (is_close) begin
      cnt_nxt = '0;
    end

    for (int i = 0; i < STACK_DEPTH; i++) begin
      cell_ctrl[i].op = CELL_HOLD;
      if (in_fire) begin
        if (push_ok) begin
          cell_ctrl[i].op = CELL_TAKE_UP;
        end else if (merge) begin
          if (i == 0) begin
            cell_ctrl[i].op = CELL_TAKE_UP;
          end else if (take_a && take_b) begin
            cell_ctrl[i].op = CELL_TAKE_DN2;
          end else if (take_a || take_b) begin
            cell_ctrl[i].op = CELL_TAKE_DN1;
          end
        end
      end
    end
  end

  // The row of stack cells.
  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    logic [LENGTH_WIDTH-1:0] up_v, dn1_v, dn2_v;
    if (i == 0) begin : g_up_top
      assign up_v = top_load;
    end else begin : g_up_cell
      assign up_v = cell_val[i-1];
    end
    if (i + 1 < STACK_DEPTH) begin : g_dn1_cell
      assign dn1_v = cell_val[i+1];
    end else begin : g_dn1_none
      assign dn1_v = '0;
    end
    if (i + 2 < STACK_DEPTH) begin : g_dn2_cell
      assign dn2_v = cell_val[i+2];
    end else begin : g_dn2_none
      assign dn2_v = '0;
    end
    lvp_cell #(
      .LENGTH_WIDTH(LENGTH_WIDTH)
    ) u_cell (
      .clk     (clk),
      .ctrl    (cell_ctrl[i]),
      .up_val  (up_v),
      .dn1_val (dn1_v),
      .dn2_val (dn2_v),
      .val     (cell_val[i])
    );
  end

  // The reported best length is the low 16 bits of the internal best.
  logic [LENGTH_WIDTH+BestWidth-1:0] best_ext;
  assign best_ext = {{BestWidth{1'b0}}, best_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      best_r      <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        cnt_r       <= cnt_nxt;
        best_r      <= best_nxt;
        ovf_r       <= ovf_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data_r.best_length <= best_ext[BestWidth-1:0];
      out_data_r.overflow    <= ovf_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // The fill count never goes past the number of cells.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CntFull)
    else $error("stack fill count exceeds depth");

  // An accepted open bracket with room leaves a marker on top.
  a_push_marker: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && push_ok |=> cell_val[0] == '0)
    else $error("open bracket did not push a marker");

  // Without a start request the best length never shrinks.
  a_best_mono: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && !in_data.start_req |=> best_r >= $past(best_r))
    else $error("best length decreased within a string");

  // A start request on an ignored character reports an empty result.
  a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_data.start_req && !is_open && !is_close |=>
      out_valid && !out_data.overflow && best_r == '0)
    else $error("start request did not clear the state");

endmodule
